// ----- design/e2q_pkg.sv -----
// e2q_pkg: shared types and constants for the euler to quaternion block
// no dependencies
`default_nettype none
package e2q_pkg;

    localparam int MAX_STAGES = 24;

    localparam longint HALF_PI_Q30    = 64'sd1686629713;
    localparam longint QUARTER_PI_Q30 = 64'sd843314856;
    localparam longint GAIN_Q30       = 64'sd652032874;
    localparam longint GAIN_CORR_Q30  = 64'sd434688583;
    localparam int     Q14_ONE        = 16384;

    localparam logic [31:0] ATAN_Q30 [MAX_STAGES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_scalar;
    } t_quat;

    // one rotation lane: cordic vector, residual angle and quadrant
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [31:0] z;
        logic [2:0]         q;
    } t_rot;

    // lane 0 roll, lane 1 pitch, lane 2 yaw
    typedef t_rot [2:0] t_rot3;

endpackage
`default_nettype wire

// ----- design/e2q_fold.sv -----
// e2q_fold: halves one angle and folds it into a quadrant and a residual
// depends on e2q_pkg
`default_nettype none
module e2q_fold (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_angle,
    output logic signed [31:0]      o_z,
    output logic [2:0]              o_q
);

    localparam logic signed [35:0] OFFSET =
        36'(e2q_pkg::QUARTER_PI_Q30 + 3 * e2q_pkg::HALF_PI_Q30);

    logic signed [35:0] n_t;
    logic signed [35:0] r_t;
    logic [2:0]         n_q;
    logic [2:0]         r_q;
    logic signed [35:0] zoff [8];
    logic signed [35:0] z_full;

    // quadrant base plus an eighth turn for every quadrant code
    always_comb begin
        for (int m = 0; m < 8; m++) begin
            zoff[m] = 36'(longint'(m) * e2q_pkg::HALF_PI_Q30 + e2q_pkg::QUARTER_PI_Q30);
        end
    end

    always_comb begin
        n_t = $signed({{3{i_angle[15]}}, i_angle, 17'd0}) + OFFSET;
        n_q = 3'd0;
        // t is always positive here and below seven quarter turns
        for (int m = 1; m < 7; m++) begin
            n_q = n_q + 3'(n_t >= 36'(longint'(m) * e2q_pkg::HALF_PI_Q30));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
            r_q <= n_q;
        end
    end

    assign z_full = r_t - zoff[r_q];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_z <= z_full[31:0];
            o_q <= r_q;
        end
    end

endmodule
`default_nettype wire

// ----- design/e2q_cordic_cell.sv -----
// e2q_cordic_cell: one rotation step of the cordic chain for all three lanes
// depends on e2q_pkg
`default_nettype none
module e2q_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire e2q_pkg::t_rot3 i_data,
    output e2q_pkg::t_rot3     o_data
);

    localparam logic signed [31:0] ANGLE = $signed(e2q_pkg::ATAN_Q30[STAGE]);

    e2q_pkg::t_rot3     n_data;
    logic signed [32:0] dx [3];
    logic signed [32:0] dy [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dx[l] = i_data[l].y >>> STAGE;
            dy[l] = i_data[l].x >>> STAGE;
            n_data[l].q = i_data[l].q;
            if (!i_data[l].z[31]) begin
                n_data[l].x = i_data[l].x - dx[l];
                n_data[l].y = i_data[l].y + dy[l];
                n_data[l].z = i_data[l].z - ANGLE;
            end else begin
                n_data[l].x = i_data[l].x + dx[l];
                n_data[l].y = i_data[l].y - dy[l];
                n_data[l].z = i_data[l].z + ANGLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= n_data;
        end
    end

endmodule
`default_nettype wire

// ----- design/e2q_combine.sv -----
// e2q_combine: unfolds sine and cosine, forms the triple products, rounds
// and saturates to q1.14; depends on e2q_pkg
`default_nettype none
module e2q_combine (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire e2q_pkg::t_rot3 i_rot,
    output e2q_pkg::t_quat      o_quat
);

    // per component: first term fa*pa, second term fb*pb, added or subtracted
    localparam int PA_SEL [4] = '{0, 2, 3, 0};
    localparam int PB_SEL [4] = '{1, 3, 2, 1};
    localparam bit FA_S   [4] = '{1'b1, 1'b0, 1'b0, 1'b0};
    localparam bit FB_S   [4] = '{1'b0, 1'b1, 1'b1, 1'b1};
    localparam bit B_NEG  [4] = '{1'b1, 1'b0, 1'b1, 1'b0};

    logic signed [32:0] s_raw [3];
    logic signed [32:0] c_raw [3];
    logic signed [33:0] s_rnd [3];
    logic signed [33:0] c_rnd [3];
    logic signed [21:0] r_s [3];
    logic signed [21:0] r_c [3];

    logic signed [43:0] r_p [4];
    logic signed [21:0] r_sc;
    logic signed [21:0] r_cc;

    logic signed [44:0] r_ah [4];
    logic signed [43:0] r_al [4];
    logic signed [44:0] r_bh [4];
    logic signed [43:0] r_bl [4];

    logic signed [45:0] r_hi [4];
    logic signed [44:0] r_lo [4];

    logic signed [21:0] fa [4];
    logic signed [21:0] fb [4];
    logic signed [22:0] pah [4];
    logic signed [21:0] pal [4];
    logic signed [22:0] pbh [4];
    logic signed [21:0] pbl [4];
    logic signed [44:0] n_ah [4];
    logic signed [43:0] n_al [4];
    logic signed [44:0] n_bh [4];
    logic signed [43:0] n_bl [4];

    logic signed [67:0] v [4];
    logic signed [21:0] rq [4];
    logic signed [15:0] sat [4];

    // quadrant unfold and rounding to q20
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            unique case (2'(i_rot[l].q[1:0] + 2'd1))
                2'd0: begin
                    s_raw[l] = i_rot[l].y;
                    c_raw[l] = i_rot[l].x;
                end
                2'd1: begin
                    s_raw[l] = i_rot[l].x;
                    c_raw[l] = -i_rot[l].y;
                end
                2'd2: begin
                    s_raw[l] = -i_rot[l].y;
                    c_raw[l] = -i_rot[l].x;
                end
                default: begin
                    s_raw[l] = -i_rot[l].x;
                    c_raw[l] = i_rot[l].y;
                end
            endcase
            s_rnd[l] = 34'(s_raw[l]) + 34'sd512;
            c_rnd[l] = 34'(c_raw[l]) + 34'sd512;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_s[l] <= s_rnd[l][31:10];
                r_c[l] <= c_rnd[l][31:10];
            end
        end
    end

    // pitch/roll pair products: cb*ca, sb*sa, sb*ca, cb*sa
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= r_c[1] * r_c[0];
            r_p[1] <= r_s[1] * r_s[0];
            r_p[2] <= r_s[1] * r_c[0];
            r_p[3] <= r_c[1] * r_s[0];
            r_sc   <= r_s[2];
            r_cc   <= r_c[2];
        end
    end

    // yaw factor times pair product, pair product split in high and low halves
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            fa[m]   = FA_S[m] ? r_sc : r_cc;
            fb[m]   = FB_S[m] ? r_sc : r_cc;
            pah[m]  = r_p[PA_SEL[m]][43:21];
            pal[m]  = $signed({1'b0, r_p[PA_SEL[m]][20:0]});
            pbh[m]  = r_p[PB_SEL[m]][43:21];
            pbl[m]  = $signed({1'b0, r_p[PB_SEL[m]][20:0]});
            n_ah[m] = fa[m] * pah[m];
            n_al[m] = fa[m] * pal[m];
            n_bh[m] = fb[m] * pbh[m];
            n_bl[m] = fb[m] * pbl[m];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ah <= n_ah;
            r_al <= n_al;
            r_bh <= n_bh;
            r_bl <= n_bl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 4; m++) begin
                if (B_NEG[m]) begin
                    r_hi[m] <= 46'(r_ah[m]) - 46'(r_bh[m]);
                    r_lo[m] <= 45'(r_al[m]) - 45'(r_bl[m]);
                end else begin
                    r_hi[m] <= 46'(r_ah[m]) + 46'(r_bh[m]);
                    r_lo[m] <= 45'(r_al[m]) + 45'(r_bl[m]);
                end
            end
        end
    end

    // q60 to q14 with round to nearest, then clamp at plus or minus one
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            v[m]  = (68'(r_hi[m]) <<< 21) + 68'(r_lo[m]) + (68'sd1 <<< 45);
            rq[m] = v[m][67:46];
            if (rq[m] > 22'(e2q_pkg::Q14_ONE)) begin
                sat[m] = 16'(e2q_pkg::Q14_ONE);
            end else if (rq[m] < -22'(e2q_pkg::Q14_ONE)) begin
                sat[m] = -16'(e2q_pkg::Q14_ONE);
            end else begin
                sat[m] = rq[m][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quat.quat_x      <= sat[0];
            o_quat.quat_y      <= sat[1];
            o_quat.quat_z      <= sat[2];
            o_quat.quat_scalar <= sat[3];
        end
    end

endmodule
`default_nettype wire

// ----- design/euler_to_quaternion.sv -----
// euler_to_quaternion: roll, pitch, yaw in q3.12 to a unit quaternion in q1.14
// path: the fold registers, the cordic cells (clamped at 24 stages), then the combine registers
// throughput: one request per cycle; the whole pipe holds while a result is stalled
// reset: synchronous active-low reset clears the valid chain; data registers are not reset
// depends on e2q_pkg, e2q_fold, e2q_cordic_cell, e2q_combine
`default_nettype none
module euler_to_quaternion #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire e2q_pkg::t_angles i_angles,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output e2q_pkg::t_quat       o_quat
);

    localparam int NSTG = (CORDIC_STAGES > e2q_pkg::MAX_STAGES) ?
                          e2q_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int DEPTH = NSTG + 7;
    localparam logic signed [32:0] GAIN =
        33'(e2q_pkg::GAIN_Q30 + (e2q_pkg::GAIN_CORR_Q30 >>> (2 * NSTG)));

    logic               advance;
    logic [DEPTH-1:0]   r_valid;
    logic signed [31:0] fold_z [3];
    logic [2:0]         fold_q [3];
    logic signed [15:0] angle [3];
    e2q_pkg::t_rot3     chain [NSTG+1];

    assign advance = !r_valid[DEPTH-1] || !i_stall;
    assign o_stall = !advance;
    assign o_valid = r_valid[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (advance) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    assign angle[0] = i_angles.roll_angle;
    assign angle[1] = i_angles.pitch_angle;
    assign angle[2] = i_angles.yaw_angle;

    for (genvar l = 0; l < 3; l++) begin : g_fold
        e2q_fold u_fold (
            .i_clk   (i_clk),
            .i_en    (advance),
            .i_angle (angle[l]),
            .o_z     (fold_z[l]),
            .o_q     (fold_q[l])
        );
        assign chain[0][l].x = GAIN;
        assign chain[0][l].y = '0;
        assign chain[0][l].z = fold_z[l];
        assign chain[0][l].q = fold_q[l];
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_cell
        e2q_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (advance),
            .i_data (chain[g]),
            .o_data (chain[g+1])
        );
    end

    e2q_combine u_combine (
        .i_clk  (i_clk),
        .i_en   (advance),
        .i_rot  (chain[NSTG]),
        .o_quat (o_quat)
    );

endmodule
`default_nettype wire
